// ----- rtl/vfc_pkg.sv -----
// vfc_pkg: constants and types for the vehicle footprint corners block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vfc_pkg;

  // cordic gain and angle constants
  localparam logic signed [33:0] KQ30       = 34'sd652032875;
  localparam logic [23:0]        KQ24       = 24'd10188014;
  localparam logic signed [33:0] PiQ29      = 34'sd1686629713;
  localparam logic signed [33:0] HalfPiQ29  = 34'sd843314857;
  localparam logic [23:0]        OneMQ16    = 24'd65536;
  localparam logic [13:0]        FifthQ16   = 14'd13107;

  // register addresses (byte address / 4)
  localparam logic [1:0] RegRear  = 2'd0;
  localparam logic [1:0] RegFront = 2'd1;
  localparam logic [1:0] RegWidth = 2'd2;

  // arctangent table, Q29
  function automatic logic signed [33:0] atan_q29(input int unsigned idx);
    logic signed [33:0] r;
    begin
      unique case (idx)
        0:  r = 34'sd421657428;
        1:  r = 34'sd248918915;
        2:  r = 34'sd131521918;
        3:  r = 34'sd66762579;
        4:  r = 34'sd33510843;
        5:  r = 34'sd16771758;
        6:  r = 34'sd8387925;
        7:  r = 34'sd4194219;
        8:  r = 34'sd2097141;
        9:  r = 34'sd1048575;
        default: r = 34'sd1 <<< (29 - idx);
      endcase
      return r;
    end
  endfunction

  // per-stage pipeline payload
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               neg;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [33:0] rz;
    logic signed [39:0] vx;
    logic signed [39:0] vy;
  } cordic_t;

endpackage
`default_nettype wire

// ----- rtl/vehicle_footprint_corners_core.sv -----
// vehicle_footprint_corners_core: oriented rectangle corners of a vehicle pose
// depends on vfc_pkg
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  s_axis beat: tdata = {vel_y, vel_x, heading, pos_y, pos_x} (pos_x lowest).
//  m_axis beat: tdata = eight 32-bit corner coordinates, tail_left_x lowest,
//    then tail_left_y, tail_right_x/y, head_right_x/y, head_left_x/y.
//  APB registers at 0x0 rear_overhang, 0x4 front_overhang, 0x8 body_width.
//  Throughput: one beat per cycle while m_axis does not stall. The path runs
//  through the seed register, the pipelined sine/cosine and magnitude CORDICs
//  (one iteration per stage), then six multiply, sum and rounding stages
//  behind them; m_axis_tvalid is the valid bit of the last of these.
//  Reset clears all valid bits and loads the register reset values.
//  A stall on m_axis freezes the whole pipeline; s_axis_tready follows the
//  output side, so every stage holds its beat and nothing is lost.
//  Configuration must be written only while the pipeline is empty.
module vehicle_footprint_corners_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], vel_x[103:80], vel_y[127:104]
  input  wire  [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tl_x, tl_y, tr_x, tr_y, hr_x, hr_y, hl_x, hl_y, 32 bits each, from bit 0
  output logic [255:0] m_axis_tdata,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import vfc_pkg::*;

  localparam int unsigned NS = CORDIC_STAGES;

  // pipeline advance
  logic adv;
  assign adv = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv;

  // configuration registers
  logic [23:0] rear_q, front_q, width_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rear_q  <= 24'd65536;
      front_q <= 24'd196608;
      width_q <= 24'd117965;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegRear:  rear_q  <= pwdata[23:0];
        RegFront: front_q <= pwdata[23:0];
        RegWidth: width_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      RegRear:  prdata = {8'd0, rear_q};
      RegFront: prdata = {8'd0, front_q};
      RegWidth: prdata = {8'd0, width_q};
      default:  prdata = 32'd0;
    endcase
  end

  // stage 0: angle folding and cordic seeds
  cordic_t st_q [NS+1];
  logic    vld_q [NS+1];
  cordic_t seed;
  always_comb begin
    logic signed [33:0] z;
    logic signed [23:0] vx, vy;
    z  = 34'(signed'(s_axis_tdata[79:64])) <<< 16;
    vx = s_axis_tdata[103:80];
    vy = s_axis_tdata[127:104];
    seed.pos_x = s_axis_tdata[31:0];
    seed.pos_y = s_axis_tdata[63:32];
    seed.neg = 1'b0;
    if (z > HalfPiQ29) begin
      z = z - PiQ29; seed.neg = 1'b1;
    end else if (z < -HalfPiQ29) begin
      z = z + PiQ29; seed.neg = 1'b1;
    end
    seed.rx = KQ30;
    seed.ry = '0;
    seed.rz = z;
    seed.vx = (vx < 0) ? -(40'(vx) <<< 14) : (40'(vx) <<< 14);
    seed.vy = 40'(vy) <<< 14;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (adv) vld_q[0] <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) st_q[0] <= seed;
  end

  // cordic iterations, one per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    cordic_t nx;
    always_comb begin
      nx = st_q[i];
      if (st_q[i].rz >= 0) begin
        nx.rx = st_q[i].rx - (st_q[i].ry >>> i);
        nx.ry = st_q[i].ry + (st_q[i].rx >>> i);
        nx.rz = st_q[i].rz - atan_q29(i);
      end else begin
        nx.rx = st_q[i].rx + (st_q[i].ry >>> i);
        nx.ry = st_q[i].ry - (st_q[i].rx >>> i);
        nx.rz = st_q[i].rz + atan_q29(i);
      end
      if (st_q[i].vy >= 0) begin
        nx.vx = st_q[i].vx + (st_q[i].vy >>> i);
        nx.vy = st_q[i].vy - (st_q[i].vx >>> i);
      end else begin
        nx.vx = st_q[i].vx - (st_q[i].vy >>> i);
        nx.vy = st_q[i].vy + (st_q[i].vx >>> i);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i+1] <= 1'b0;
      else if (adv) vld_q[i+1] <= vld_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) st_q[i+1] <= nx;
    end
  end

  // stage a: sign fix, speed gain multiply
  logic               va_q;
  logic signed [31:0] pxa_q, pya_q;
  logic signed [33:0] ca_q, sa_q;
  logic [63:0]        spm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= vld_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxa_q <= st_q[NS].pos_x;
      pya_q <= st_q[NS].pos_y;
      ca_q  <= st_q[NS].neg ? -st_q[NS].rx : st_q[NS].rx;
      sa_q  <= st_q[NS].neg ? -st_q[NS].ry : st_q[NS].ry;
      spm_q <= 64'(st_q[NS].vx[39:0]) * 64'(KQ24);
    end
  end

  // stage b: speed times one fifth
  logic               vb_q;
  logic signed [31:0] pxb_q, pyb_q;
  logic signed [33:0] cb_q, sb_q;
  logic [39:0]        fifth_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (adv) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxb_q <= pxa_q; pyb_q <= pya_q; cb_q <= ca_q; sb_q <= sa_q;
      fifth_q <= 40'(spm_q[63:38]) * 40'(FifthQ16);
    end
  end

  // stage c: head length
  logic               vc_q;
  logic signed [31:0] pxc_q, pyc_q;
  logic signed [33:0] cc_q, sc_q;
  logic [26:0]        head_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (adv) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxc_q <= pxb_q; pyc_q <= pyb_q; cc_q <= cb_q; sc_q <= sb_q;
      head_q <= 27'(front_q) + 27'(OneMQ16) + 27'(fifth_q[39:16]);
    end
  end

  // stage d: trig times lengths
  logic               vd_q;
  logic signed [63:0] pxd_q, pyd_q, cr_q, sr_q, ch_q, sh_q, sw_q, cw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (adv) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxd_q <= 64'(pxc_q) <<< 31;
      pyd_q <= 64'(pyc_q) <<< 31;
      cr_q  <= (64'(cc_q) * 64'(signed'({1'b0, rear_q}))) <<< 1;
      sr_q  <= (64'(sc_q) * 64'(signed'({1'b0, rear_q}))) <<< 1;
      ch_q  <= (64'(cc_q) * 64'(signed'({1'b0, head_q}))) <<< 1;
      sh_q  <= (64'(sc_q) * 64'(signed'({1'b0, head_q}))) <<< 1;
      sw_q  <= 64'(sc_q) * 64'(signed'({1'b0, width_q}));
      cw_q  <= 64'(cc_q) * 64'(signed'({1'b0, width_q}));
    end
  end

  // stage e: edge centers
  logic               ve_q;
  logic signed [63:0] tx_q, ty_q, hx_q, hy_q, swe_q, cwe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (adv) ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q <= pxd_q - cr_q; ty_q <= pyd_q - sr_q;
      hx_q <= pxd_q + ch_q; hy_q <= pyd_q + sh_q;
      swe_q <= sw_q; cwe_q <= cw_q;
    end
  end

  // stage f: corners, round and saturate
  function automatic logic [31:0] fin(input logic signed [63:0] a);
    logic signed [63:0] v;
    begin
      v = (a + (64'sd1 <<< 30)) >>> 31;
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    end
  endfunction

  logic         vf_q;
  logic [255:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (adv) vf_q <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {fin(hy_q + cwe_q), fin(hx_q - swe_q),
                fin(hy_q - cwe_q), fin(hx_q + swe_q),
                fin(ty_q - cwe_q), fin(tx_q + swe_q),
                fin(ty_q + cwe_q), fin(tx_q - swe_q)};
    end
  end
  assign m_axis_tvalid = vf_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire
